// File: hdl/msb_first_bit_packer_assert.svh
// Assertion macros shared by the packer checker.
`ifndef MSB_FIRST_BIT_PACKER_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define MBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also runs during reset.
`define MBP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/msbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
package msbp_pkg;

    localparam int BYTE_BITS = 8;

    localparam logic [3:0] FREE_EMPTY = 4'd8;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPEND,
        ST_FLUSH
    } state_t;

    // Sequencer to window shifter control.
    typedef struct packed {
        logic       load;
        logic       shift;
        logic [3:0] amt;
    } win_ctrl_t;

endpackage

// File: hdl/msbp_window.sv
// Field window: MSB-aligns the field on load, then shifts it left by up to 8 bits a step.
module msbp_window #(
    parameter int MAX_FIELD_BITS = 64,
    parameter int RW = 7
) (
    input  logic                      aclk,
    input  msbp_pkg::win_ctrl_t       ctrl,
    input  logic [MAX_FIELD_BITS-1:0] load_value,
    input  logic [RW-1:0]             load_width,
    output logic [7:0]                top_byte
);
    import msbp_pkg::*;

    localparam logic [RW-1:0] MAX_W = RW'(MAX_FIELD_BITS);

    logic [MAX_FIELD_BITS-1:0] win_reg;
    logic [MAX_FIELD_BITS-1:0] win_next;
    logic [RW-1:0]             align_amt;

    // bits above the field width fall off the top; bits below stay zero
    assign align_amt = MAX_W - load_width;

    always_comb begin
        win_next = win_reg;
        if (ctrl.load) begin
            win_next = load_value << align_amt;
        end else if (ctrl.shift) begin
            win_next = win_reg << ctrl.amt;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign top_byte = win_reg[MAX_FIELD_BITS-1 -: BYTE_BITS];

endmodule

// File: hdl/msb_first_bit_packer.sv
// MSB-first bit packer top level: sequencer, partial byte and output register.
//
//  channel | ports                                   | dir | beat
//  --------+-----------------------------------------+-----+---------------------
//  input   | s_valid s_ready s_action s_field_width  | in  | one append or flush
//          | s_field_value                           |     |
//  result  | m_valid m_ready m_out_byte              | out | one packed byte
//          | m_last_of_run                           |     |
//
// An append loads the field into the window, emits each completed byte, then merges
// the leftover bits into the partial byte; the window shifter moves at most one byte
// a step. A flush sends any pending bits as a last byte; an oversize append is dropped.
// s_ready is high only while the sequencer is idle. A stalled m_ready holds the
// sequencer at the next byte. Reset empties the partial byte and clears m_valid.
module msb_first_bit_packer #(
    parameter int MAX_FIELD_BITS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [6:0]                s_field_width,
    input  logic [MAX_FIELD_BITS-1:0] s_field_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_last_of_run
);
    import msbp_pkg::*;

    localparam int RW = $clog2(MAX_FIELD_BITS + 1);
    localparam logic [6:0] MAX_W7 = 7'(MAX_FIELD_BITS);

    state_t        state_reg, state_next;
    logic [7:0]    partial_reg, partial_next;
    logic [3:0]    free_reg, free_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;

    win_ctrl_t     wctrl;
    logic [7:0]    top_byte;
    logic [7:0]    chunk;
    logic [RW-1:0] rem_after;
    logic          slot_free;
    logic          accept;
    logic          width_ok;
    logic          can_emit;

    msbp_window #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .RW(RW)
    ) u_window (
        .aclk      (aclk),
        .ctrl      (wctrl),
        .load_value(s_field_value),
        .load_width(s_field_width[RW-1:0]),
        .top_byte  (top_byte)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign width_ok  = (s_field_width <= MAX_W7);
    assign slot_free = !m_valid_reg || m_ready;
    assign can_emit  = (rem_reg >= RW'(free_reg));
    assign rem_after = rem_reg - RW'(free_reg);
    // window bits below the remaining count are zero, so this also serves the merge
    assign chunk     = top_byte >> (4'd8 - free_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_FLUSH) begin
                        state_next = ST_FLUSH;
                    end else if (width_ok) begin
                        state_next = ST_APPEND;
                    end
                end
            end
            ST_APPEND: begin
                if (!can_emit) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (free_reg == FREE_EMPTY || slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        partial_next = partial_reg;
        free_next    = free_reg;
        rem_next     = rem_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        wctrl        = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_action == ACT_APPEND && width_ok) begin
                    wctrl.load = 1'b1;
                    rem_next   = s_field_width[RW-1:0];
                end
            end
            ST_APPEND: begin
                if (can_emit) begin
                    if (slot_free) begin
                        byte_next    = partial_reg | chunk;
                        last_next    = (rem_after < RW'(BYTE_BITS));
                        m_valid_next = 1'b1;
                        partial_next = 8'd0;
                        free_next    = FREE_EMPTY;
                        rem_next     = rem_after;
                        wctrl.shift  = 1'b1;
                        wctrl.amt    = free_reg;
                    end
                end else begin
                    // fewer bits left than free slots: merge into the partial byte
                    partial_next = partial_reg | chunk;
                    free_next    = free_reg - rem_reg[3:0];
                end
            end
            ST_FLUSH: begin
                if (free_reg == FREE_EMPTY) begin
                    partial_next = 8'd0;
                end else if (slot_free) begin
                    byte_next    = partial_reg;
                    last_next    = 1'b1;
                    m_valid_next = 1'b1;
                    partial_next = 8'd0;
                    free_next    = FREE_EMPTY;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            partial_reg <= 8'd0;
            free_reg    <= FREE_EMPTY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            partial_reg <= partial_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

// File: hdl/msbp_checker.sv
// Port-level checks for the MSB-first bit packer, bound to the top level.
`include "msb_first_bit_packer_assert.svh"

module msbp_checker #(
    parameter int MAX_FIELD_BITS = 64
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      s_action,
    input logic [6:0]                s_field_width,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [7:0]                m_out_byte,
    input logic                      m_last_of_run
);
    localparam logic [6:0] MAX_W7 = 7'(MAX_FIELD_BITS);

    logic in_beat;
    logic works;

    assign in_beat = s_valid && s_ready;
    // every item but an oversize append takes the sequencer out of idle, so s_ready drops
    assign works   = s_action || (s_field_width <= MAX_W7);

    `MBP_ASSERT(a_out_hold, (m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_of_run)), "result beat changed while stalled")
    `MBP_ASSERT_RST(a_rst_empty, (!aresetn |=> !m_valid), "result valid right after reset")
    `MBP_ASSERT(a_busy_after, (in_beat && works |=> !s_ready), "ready stayed high after an item")
    `MBP_ASSERT(a_mid_run, (m_valid && !m_last_of_run |-> !s_ready), "ready high while a run is unfinished")

endmodule

bind msb_first_bit_packer msbp_checker #(.MAX_FIELD_BITS(MAX_FIELD_BITS)) u_msbp_checker (.*);

// File: sim/tb_msb_first_bit_packer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the MSB-first bit packer: predictor, stimulus and byte checker.
module tb_msb_first_bit_packer;
    import msbp_pkg::*;

    localparam int FIELD_BITS   = 64;
    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE       = 16;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } packed_beat_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_action      = ACT_APPEND;
    logic [6:0]            s_field_width = '0;
    logic [FIELD_BITS-1:0] s_field_value = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [7:0]            m_out_byte;
    logic                  m_last_of_run;

    // predictor state: pending bits packed from bit 7 down, free positions left
    logic [7:0]   pend_byte = '0;
    logic [3:0]   pend_free = FREE_EMPTY;
    packed_beat_t beat_q[$];
    packed_beat_t want_beat;

    bit          idle_on   = 1'b1;
    int unsigned err_cnt   = 0;
    int unsigned cycle_cnt = 0;
    int unsigned stall_cnt = 0;

    msb_first_bit_packer #(
        .MAX_FIELD_BITS(FIELD_BITS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_field_width (s_field_width),
        .s_field_value (s_field_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side back-pressure: random bursts of m_ready low while idle_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else if (stall_cnt != 0) begin
            m_ready   <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_ready   <= 1'b0;
            stall_cnt <= $urandom_range(0, 12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [63:0] keep_low(input logic [63:0] v, input int n);
        if (n >= FIELD_BITS)
            return v;
        return v & ((64'd1 << n) - 64'd1);
    endfunction

    // bytes this beat completes, queued in stream order
    function automatic void pack_field(input logic act, input logic [6:0] w,
                                       input logic [63:0] v);
        int         n;
        int         made;
        logic [7:0] b;
        n    = int'(w);
        made = 0;
        if (act == ACT_FLUSH) begin
            if (pend_free < FREE_EMPTY)
                beat_q.push_back('{data: pend_byte, last: 1'b1});
            pend_byte = '0;
            pend_free = FREE_EMPTY;
            return;
        end
        if (n > FIELD_BITS)
            return;
        while (n >= int'(pend_free)) begin
            n = n - int'(pend_free);
            b = pend_byte | 8'(keep_low(v >> n, int'(pend_free)));
            beat_q.push_back('{data: b, last: 1'b0});
            made++;
            pend_byte = '0;
            pend_free = FREE_EMPTY;
        end
        pend_free = pend_free - 4'(n);
        pend_byte = pend_byte | 8'(keep_low(v, n) << pend_free);
        if (made > 0)
            beat_q[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (beat_q.size() == 0) begin
                report_mismatch("unexpected beat", m_out_byte, 8'h00);
            end else begin
                want_beat = beat_q.pop_front();
                if (m_out_byte !== want_beat.data)
                    report_mismatch("out_byte", m_out_byte, want_beat.data);
                if (m_last_of_run !== want_beat.last)
                    report_mismatch("last_of_run", 8'(m_last_of_run), 8'(want_beat.last));
            end
        end
    end

    // s_valid stays high after acceptance so back-to-back beats need one assignment
    task automatic send_item(input logic act, input logic [6:0] w, input logic [63:0] v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_field_width <= w;
        s_field_value <= v;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        pack_field(act, w, v);
    endtask

    // returns 1 when the item can change the stream
    task automatic send_random(output bit useful);
        int          pick;
        logic        act;
        logic [6:0]  w;
        logic [63:0] v;
        pick = $urandom_range(0, 99);
        act  = ACT_APPEND;
        case ($urandom_range(0, 9))
            0:       v = '1;
            1:       v = '0;
            default: v = {$urandom, $urandom};
        endcase
        if (pick < 12) begin
            act = ACT_FLUSH;
            w   = 7'($urandom_range(0, 127));
        end else if (pick < 16) begin
            w = 7'($urandom_range(FIELD_BITS + 1, 127));
        end else if (pick < 20) begin
            w = '0;
        end else if (pick < 60) begin
            w = 7'($urandom_range(1, 16));
        end else begin
            w = 7'($urandom_range(17, FIELD_BITS));
        end
        useful = (act == ACT_FLUSH) || (w != 0 && int'(w) <= FIELD_BITS);
        send_item(act, w, v);
    endtask

    task automatic test_directed_cases();
        send_item(ACT_APPEND, 7'd64,  '1);
        send_item(ACT_APPEND, 7'd64,  '0);
        send_item(ACT_APPEND, 7'd0,   '1);                  // zero width
        send_item(ACT_APPEND, 7'd65,  64'h0123_4567_89AB_CDEF); // oversize
        send_item(ACT_APPEND, 7'd127, '1);
        send_item(ACT_FLUSH,  7'd0,   '0);                  // nothing pending
        send_item(ACT_APPEND, 7'd1,   '1);                  // upper bits masked off
        send_item(ACT_FLUSH,  7'd127, '1);                  // fields ignored on flush
        send_item(ACT_APPEND, 7'd3,   64'h5);
        send_item(ACT_APPEND, 7'd5,   64'hFFFF_FFFF_FFFF_FF1A);
        send_item(ACT_APPEND, 7'd7,   64'h55);
        send_item(ACT_APPEND, 7'd64,  64'h0123_4567_89AB_CDEF); // completes 8 bytes
        send_item(ACT_APPEND, 7'd63,  64'hAAAA_AAAA_AAAA_AAAA);
        send_item(ACT_APPEND, 7'd1,   '0);
        send_item(ACT_APPEND, 7'd8,   64'hA5);
        send_item(ACT_APPEND, 7'd7,   64'h7F);
        send_item(ACT_APPEND, 7'd9,   64'h1_5A);
        send_item(ACT_FLUSH,  7'd0,   '0);
        send_item(ACT_FLUSH,  7'd64,  '0);
        send_item(ACT_APPEND, 7'd2,   64'h2);
        send_item(ACT_APPEND, 7'd0,   64'h1);
        send_item(ACT_FLUSH,  7'd8,   64'hFF);
    endtask

    task automatic test_random_traffic(input int items);
        int cnt;
        bit useful;
        cnt = 0;
        while (cnt < items) begin
            send_random(useful);
            if (useful)
                cnt++;
        end
    endtask

    task automatic test_back_to_back(input int items);
        idle_on = 1'b0;
        test_random_traffic(items);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_traffic(100);
        test_back_to_back(32);
        send_item(ACT_FLUSH, 7'd0, '0);

        s_valid <= 1'b0;
        while (beat_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
